>>> rtl/whp_pkg.sv
package whp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [9:0] MS_PER_S = 10'd1000;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_NOT_RIFF  = 3'd1;
    localparam logic [2:0] STATUS_NOT_WAVE  = 3'd2;
    localparam logic [2:0] STATUS_NOT_PCM   = 3'd3;
    localparam logic [2:0] STATUS_CHANNELS  = 3'd4;

    localparam logic [15:0] FORMAT_PCM   = 16'd1;
    localparam logic [15:0] MAX_CHANNELS = 16'd2;

    localparam int DIVIDEND_W = 44;
    localparam int DIVISOR_W  = 32;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    typedef enum logic [3:0] {
        PH_RIFF,
        PH_RSIZE,
        PH_WAVE,
        PH_CTAG,
        PH_CSIZE,
        PH_FTAG,
        PH_CHAN,
        PH_RATE,
        PH_BRATE,
        PH_ALIGN,
        PH_BITS,
        PH_SKIP,
        PH_DONE
    } whp_phase_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_LAUNCH,
        SEQ_DIV
    } whp_seq_t;

    typedef struct packed {
        logic busy;
        logic done;
    } whp_div_stat_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       start_of_file;
    } whp_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] channels;
        logic [15:0] bits_per_sample;
        logic        bits_supported;
        logic [31:0] sample_rate;
        logic [31:0] payload_size;
        logic [31:0] payload_offset;
        logic [31:0] duration_ms;
    } whp_out_t;

endpackage

>>> rtl/whp_divider.sv
module whp_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [whp_pkg::DIVIDEND_W-1:0]      dividend,
    input  logic [whp_pkg::DIVISOR_W-1:0]       divisor,
    output whp_pkg::whp_div_stat_t              stat,
    output logic [whp_pkg::DIVIDEND_W-1:0]      quotient
);

    logic [whp_pkg::DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [whp_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [whp_pkg::DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [whp_pkg::DIV_CNT_W-1:0]  count_reg, count_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [whp_pkg::DIVISOR_W:0]    rem_shift;
    logic [whp_pkg::DIVISOR_W:0]    rem_diff;
    logic                           fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[whp_pkg::DIVIDEND_W-1]};
        fits      = rem_shift >= {1'b0, dsr_reg};
        rem_diff  = rem_shift - {1'b0, dsr_reg};

        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;

        if (start)
        begin
            rem_next   = '0;
            quo_next   = dividend;
            dsr_next   = divisor;
            count_next = whp_pkg::DIV_CNT_W'(whp_pkg::DIVIDEND_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? rem_diff[whp_pkg::DIVISOR_W-1:0]
                              : rem_shift[whp_pkg::DIVISOR_W-1:0];
            quo_next   = {quo_reg[whp_pkg::DIVIDEND_W-2:0], fits};
            count_next = count_reg - 1'b1;
            if (count_reg == whp_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

>>> rtl/wav_header_parser.sv
// channel  dir  payload              handshake
// byte     in   whp_pkg::whp_in_t    byte_valid / byte_ready
// result   out  whp_pkg::whp_out_t   result_valid / result_ready
//
// one file byte per cycle while parsing; an error result is registered in the
// cycle of the byte that causes it
// an ok result passes through a launch state (x1000 product), the bit-serial
// divider and the result register (the divider is skipped for a zero byte rate)
// byte_ready is low meanwhile and while a result beat waits for result_ready
// reset clears all control state; the parser then expects the RIFF tag
module wav_header_parser #(
    parameter int OFFSET_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  whp_pkg::whp_in_t  byte_data,
    output logic              result_valid,
    input  logic              result_ready,
    output whp_pkg::whp_out_t result_data
);

    whp_pkg::whp_phase_t     phase_reg, phase_next, phase_cur;
    logic [31:0]             shift_reg, shift_next, shift_cur, word;
    logic [1:0]              count_reg, count_next, count_cur;
    logic [OFFSET_BITS-1:0]  offset_reg, offset_next, offset_cur;
    logic [31:0]             chunk_rem_reg, chunk_rem_next, chunk_rem_cur;
    logic [31:0]             chunk_tag_reg, chunk_tag_next, chunk_tag_cur;
    logic [31:0]             riff_size_reg, riff_size_next, riff_size_cur;
    logic                    fmt_seen_reg, fmt_seen_next, fmt_seen_cur;
    logic [15:0]             channels_reg, channels_next, channels_cur;
    logic [15:0]             bits_reg, bits_next, bits_cur;
    logic [31:0]             rate_reg, rate_next, rate_cur;
    logic [31:0]             byte_rate_reg, byte_rate_next, byte_rate_cur;
    logic [31:0]             data_size_reg, data_size_next, data_size_cur;
    logic [31:0]             data_offset_reg, data_offset_next, data_offset_cur;

    whp_pkg::whp_seq_t       seq_reg, seq_next;
    logic                    result_valid_reg, result_valid_next;
    whp_pkg::whp_out_t       result_data_reg, result_data_next;

    logic                    byte_fire;
    logic                    sof;
    logic                    takes;
    logic                    two_byte;
    logic                    complete;
    logic [2:0]              count_inc;
    logic                    emit_ok;
    logic                    emit_err;
    logic [2:0]              err_code;

    logic                    div_start;
    logic                    ok_write;
    logic [31:0]             duration;
    logic [whp_pkg::DIVIDEND_W-1:0] product;
    logic [whp_pkg::DIVIDEND_W-1:0] quotient;
    whp_pkg::whp_div_stat_t  div_stat;

    assign byte_ready = (seq_reg == whp_pkg::SEQ_IDLE) && !result_valid_reg;
    assign byte_fire  = byte_valid && byte_ready;
    assign sof        = byte_data.start_of_file;

    // byte parser
    always_comb
    begin
        phase_cur       = sof ? whp_pkg::PH_RIFF : phase_reg;
        shift_cur       = sof ? '0 : shift_reg;
        count_cur       = sof ? '0 : count_reg;
        offset_cur      = sof ? '0 : offset_reg;
        chunk_rem_cur   = sof ? '0 : chunk_rem_reg;
        chunk_tag_cur   = sof ? '0 : chunk_tag_reg;
        riff_size_cur   = sof ? '0 : riff_size_reg;
        fmt_seen_cur    = sof ? 1'b0 : fmt_seen_reg;
        channels_cur    = sof ? '0 : channels_reg;
        bits_cur        = sof ? '0 : bits_reg;
        rate_cur        = sof ? '0 : rate_reg;
        byte_rate_cur   = sof ? '0 : byte_rate_reg;
        data_size_cur   = sof ? '0 : data_size_reg;
        data_offset_cur = sof ? '0 : data_offset_reg;

        phase_next       = phase_cur;
        shift_next       = shift_cur;
        count_next       = count_cur;
        offset_next      = offset_cur + 1'b1;
        chunk_rem_next   = chunk_rem_cur;
        chunk_tag_next   = chunk_tag_cur;
        riff_size_next   = riff_size_cur;
        fmt_seen_next    = fmt_seen_cur;
        channels_next    = channels_cur;
        bits_next        = bits_cur;
        rate_next        = rate_cur;
        byte_rate_next   = byte_rate_cur;
        data_size_next   = data_size_cur;
        data_offset_next = data_offset_cur;
        emit_ok          = 1'b0;
        emit_err         = 1'b0;
        err_code         = whp_pkg::STATUS_OK;

        word      = {byte_data.file_byte, shift_cur[31:8]};
        two_byte  = phase_cur inside {whp_pkg::PH_FTAG, whp_pkg::PH_CHAN,
                                      whp_pkg::PH_ALIGN, whp_pkg::PH_BITS};
        takes     = phase_cur <= whp_pkg::PH_BITS;
        count_inc = {1'b0, count_cur} + 3'd1;
        complete  = takes && (count_inc >= (two_byte ? 3'd2 : 3'd4));

        if (takes)
        begin
            shift_next = word;
            count_next = complete ? 2'd0 : count_inc[1:0];
        end

        case (phase_cur)
            whp_pkg::PH_RIFF:
            begin
                if (complete)
                begin
                    if (word != whp_pkg::TAG_RIFF)
                    begin
                        emit_err   = 1'b1;
                        err_code   = whp_pkg::STATUS_NOT_RIFF;
                        phase_next = whp_pkg::PH_DONE;
                    end
                    else
                        phase_next = whp_pkg::PH_RSIZE;
                end
            end
            whp_pkg::PH_RSIZE:
            begin
                if (complete)
                begin
                    riff_size_next = word;
                    phase_next     = whp_pkg::PH_WAVE;
                end
            end
            whp_pkg::PH_WAVE:
            begin
                if (complete)
                begin
                    if (word != whp_pkg::TAG_WAVE)
                    begin
                        emit_err   = 1'b1;
                        err_code   = whp_pkg::STATUS_NOT_WAVE;
                        phase_next = whp_pkg::PH_DONE;
                    end
                    else
                        phase_next = whp_pkg::PH_CTAG;
                end
            end
            whp_pkg::PH_CTAG:
            begin
                if (complete)
                begin
                    chunk_tag_next = word;
                    phase_next     = whp_pkg::PH_CSIZE;
                end
            end
            whp_pkg::PH_CSIZE:
            begin
                if (complete)
                begin
                    chunk_rem_next = word;
                    if (chunk_tag_cur == whp_pkg::TAG_FMT)
                        phase_next = whp_pkg::PH_FTAG;
                    else if (chunk_tag_cur == whp_pkg::TAG_DATA && fmt_seen_cur)
                    begin
                        data_size_next   = word;
                        data_offset_next = 32'(offset_next);
                        emit_ok          = 1'b1;
                        phase_next       = whp_pkg::PH_DONE;
                    end
                    else
                        phase_next = (word != '0) ? whp_pkg::PH_SKIP : whp_pkg::PH_CTAG;
                end
            end
            whp_pkg::PH_FTAG:
            begin
                if (complete)
                begin
                    if (word[31:16] != whp_pkg::FORMAT_PCM)
                    begin
                        emit_err   = 1'b1;
                        err_code   = whp_pkg::STATUS_NOT_PCM;
                        phase_next = whp_pkg::PH_DONE;
                    end
                    else
                        phase_next = whp_pkg::PH_CHAN;
                end
            end
            whp_pkg::PH_CHAN:
            begin
                if (complete)
                begin
                    channels_next = word[31:16];
                    if (word[31:16] > whp_pkg::MAX_CHANNELS)
                    begin
                        emit_err   = 1'b1;
                        err_code   = whp_pkg::STATUS_CHANNELS;
                        phase_next = whp_pkg::PH_DONE;
                    end
                    else
                        phase_next = whp_pkg::PH_RATE;
                end
            end
            whp_pkg::PH_RATE:
            begin
                if (complete)
                begin
                    rate_next  = word;
                    phase_next = whp_pkg::PH_BRATE;
                end
            end
            whp_pkg::PH_BRATE:
            begin
                if (complete)
                begin
                    byte_rate_next = word;
                    phase_next     = whp_pkg::PH_ALIGN;
                end
            end
            whp_pkg::PH_ALIGN:
            begin
                if (complete)
                    phase_next = whp_pkg::PH_BITS;
            end
            whp_pkg::PH_BITS:
            begin
                if (complete)
                begin
                    bits_next      = word[31:16];
                    fmt_seen_next  = 1'b1;
                    chunk_rem_next = (chunk_rem_cur > 32'd16) ? chunk_rem_cur - 32'd16 : '0;
                    phase_next     = (chunk_rem_cur > 32'd16) ? whp_pkg::PH_SKIP
                                                              : whp_pkg::PH_CTAG;
                end
            end
            whp_pkg::PH_SKIP:
            begin
                chunk_rem_next = chunk_rem_cur - 32'd1;
                if (chunk_rem_cur == 32'd1)
                    phase_next = whp_pkg::PH_CTAG;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= whp_pkg::PH_RIFF;
            shift_reg       <= '0;
            count_reg       <= '0;
            offset_reg      <= '0;
            chunk_rem_reg   <= '0;
            chunk_tag_reg   <= '0;
            riff_size_reg   <= '0;
            fmt_seen_reg    <= 1'b0;
            channels_reg    <= '0;
            bits_reg        <= '0;
            rate_reg        <= '0;
            byte_rate_reg   <= '0;
            data_size_reg   <= '0;
            data_offset_reg <= '0;
        end
        else if (byte_fire)
        begin
            phase_reg       <= phase_next;
            shift_reg       <= shift_next;
            count_reg       <= count_next;
            offset_reg      <= offset_next;
            chunk_rem_reg   <= chunk_rem_next;
            chunk_tag_reg   <= chunk_tag_next;
            riff_size_reg   <= riff_size_next;
            fmt_seen_reg    <= fmt_seen_next;
            channels_reg    <= channels_next;
            bits_reg        <= bits_next;
            rate_reg        <= rate_next;
            byte_rate_reg   <= byte_rate_next;
            data_size_reg   <= data_size_next;
            data_offset_reg <= data_offset_next;
        end
    end

    // duration sequencer
    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            whp_pkg::SEQ_IDLE:
            begin
                if (byte_fire && emit_ok)
                    seq_next = whp_pkg::SEQ_LAUNCH;
            end
            whp_pkg::SEQ_LAUNCH:
            begin
                seq_next = (byte_rate_reg != '0) ? whp_pkg::SEQ_DIV : whp_pkg::SEQ_IDLE;
            end
            whp_pkg::SEQ_DIV:
            begin
                if (div_stat.done)
                    seq_next = whp_pkg::SEQ_IDLE;
            end
            default:
            begin
                seq_next = whp_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        ok_write  = 1'b0;
        duration  = '0;
        case (seq_reg)
            whp_pkg::SEQ_LAUNCH:
            begin
                div_start = byte_rate_reg != '0;
                ok_write  = byte_rate_reg == '0;
            end
            whp_pkg::SEQ_DIV:
            begin
                ok_write = div_stat.done;
                duration = (quotient[whp_pkg::DIVIDEND_W-1:32] != '0) ? '1 : quotient[31:0];
            end
            default:
            begin
            end
        endcase
    end

    assign product = whp_pkg::DIVIDEND_W'(riff_size_reg) * whp_pkg::DIVIDEND_W'(whp_pkg::MS_PER_S);

    whp_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (byte_rate_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // result beat register
    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_data_next  = result_data_reg;
        if (byte_fire && emit_err)
        begin
            result_valid_next        = 1'b1;
            result_data_next         = '0;
            result_data_next.status  = err_code;
        end
        else if (ok_write)
        begin
            result_valid_next                = 1'b1;
            result_data_next.status          = whp_pkg::STATUS_OK;
            result_data_next.channels        = channels_reg;
            result_data_next.bits_per_sample = bits_reg;
            result_data_next.bits_supported  = (bits_reg == 16'd8) || (bits_reg == 16'd16);
            result_data_next.sample_rate     = rate_reg;
            result_data_next.payload_size    = data_size_reg;
            result_data_next.payload_offset  = data_offset_reg;
            result_data_next.duration_ms     = duration;
        end
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg          <= whp_pkg::SEQ_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg          <= seq_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_data_reg <= result_data_next;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    a_ready_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        byte_ready |-> !result_valid && !div_stat.busy)
        else $error("byte_ready high while a result or a division is pending");

    a_launch_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == whp_pkg::SEQ_LAUNCH |=> div_stat.busy || result_valid)
        else $error("launch neither started the divider nor wrote a result");

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status != whp_pkg::STATUS_OK
            |-> result_data.channels == '0 && result_data.duration_ms == '0
                && result_data.payload_offset == '0)
        else $error("error result carries nonzero fields");

endmodule

>>> bench/whp_checker.sv
module whp_checker
    import whp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    input  logic     byte_ready,
    input  whp_in_t  byte_data,
    input  logic     result_valid,
    input  logic     result_ready,
    input  whp_out_t result_data,
    output int       errors,
    output int       waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    whp_phase_t  phase;
    logic [31:0] shift_reg;
    logic [1:0]  byte_cnt;
    logic [31:0] offset;
    logic [31:0] remaining;
    logic [31:0] chunk_id;
    logic [31:0] riff_len;
    logic        have_fmt;
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [31:0] data_size;
    logic [31:0] data_offset;

    whp_out_t expected_headers[$];
    whp_out_t want;
    int       fail_count = 0;

    assign errors = fail_count;

    task automatic clear_parse();
        phase       = PH_RIFF;
        shift_reg   = '0;
        byte_cnt    = '0;
        offset      = '0;
        remaining   = '0;
        chunk_id    = '0;
        riff_len    = '0;
        have_fmt    = 1'b0;
        chans       = '0;
        bits        = '0;
        rate        = '0;
        brate       = '0;
        data_size   = '0;
        data_offset = '0;
    endtask

    // little-endian field assembly, new byte enters at the top
    function automatic logic field_done(input logic [7:0] b, input int len);
        shift_reg = {b, shift_reg[31:8]};
        if (byte_cnt + 1 >= len)
        begin
            byte_cnt = '0;
            return 1'b1;
        end
        byte_cnt = byte_cnt + 2'd1;
        return 1'b0;
    endfunction

    task automatic push_error(input logic [2:0] code);
        whp_out_t hdr;
        hdr        = '0;
        hdr.status = code;
        expected_headers.push_back(hdr);
        phase = PH_DONE;
    endtask

    task automatic push_ok();
        whp_out_t    hdr;
        logic [63:0] quotient;
        quotient = '0;
        if (brate != '0)
        begin
            quotient = (64'(riff_len) * 64'(MS_PER_S)) / 64'(brate);
            if (quotient > 64'hFFFF_FFFF)
                quotient = 64'hFFFF_FFFF;
        end
        hdr.status          = STATUS_OK;
        hdr.channels        = chans;
        hdr.bits_per_sample = bits;
        hdr.bits_supported  = (bits == 16'd8 || bits == 16'd16);
        hdr.sample_rate     = rate;
        hdr.payload_size    = data_size;
        hdr.payload_offset  = data_offset;
        hdr.duration_ms     = quotient[31:0];
        expected_headers.push_back(hdr);
        phase = PH_DONE;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic sof);
        logic [31:0] next_off;
        if (sof)
            clear_parse();
        next_off = offset + 32'd1;
        case (phase)
            PH_RIFF:
                if (field_done(b, 4))
                begin
                    if (shift_reg != TAG_RIFF)
                        push_error(STATUS_NOT_RIFF);
                    else
                        phase = PH_RSIZE;
                end
            PH_RSIZE:
                if (field_done(b, 4))
                begin
                    riff_len = shift_reg;
                    phase    = PH_WAVE;
                end
            PH_WAVE:
                if (field_done(b, 4))
                begin
                    if (shift_reg != TAG_WAVE)
                        push_error(STATUS_NOT_WAVE);
                    else
                        phase = PH_CTAG;
                end
            PH_CTAG:
                if (field_done(b, 4))
                begin
                    chunk_id = shift_reg;
                    phase    = PH_CSIZE;
                end
            PH_CSIZE:
                if (field_done(b, 4))
                begin
                    remaining = shift_reg;
                    if (chunk_id == TAG_FMT)
                        phase = PH_FTAG;
                    else if (chunk_id == TAG_DATA && have_fmt)
                    begin
                        data_size   = shift_reg;
                        data_offset = next_off;
                        push_ok();
                    end
                    else
                        phase = (remaining != '0) ? PH_SKIP : PH_CTAG;
                end
            PH_FTAG:
                if (field_done(b, 2))
                begin
                    if (shift_reg[31:16] != FORMAT_PCM)
                        push_error(STATUS_NOT_PCM);
                    else
                        phase = PH_CHAN;
                end
            PH_CHAN:
                if (field_done(b, 2))
                begin
                    chans = shift_reg[31:16];
                    if (chans > MAX_CHANNELS)
                        push_error(STATUS_CHANNELS);
                    else
                        phase = PH_RATE;
                end
            PH_RATE:
                if (field_done(b, 4))
                begin
                    rate  = shift_reg;
                    phase = PH_BRATE;
                end
            PH_BRATE:
                if (field_done(b, 4))
                begin
                    brate = shift_reg;
                    phase = PH_ALIGN;
                end
            PH_ALIGN:
                if (field_done(b, 2))
                    phase = PH_BITS;
            PH_BITS:
                if (field_done(b, 2))
                begin
                    bits      = shift_reg[31:16];
                    have_fmt  = 1'b1;
                    remaining = (remaining > 32'd16) ? remaining - 32'd16 : '0;
                    phase     = (remaining != '0) ? PH_SKIP : PH_CTAG;
                end
            PH_SKIP:
            begin
                remaining = remaining - 32'd1;
                if (remaining == '0)
                    phase = PH_CTAG;
            end
            default:
            begin
            end
        endcase
        offset = next_off;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s expected %0h actual %0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            expected_headers.delete();
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_headers.size() == 0)
                begin
                    $error("result beat with no header expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_headers.pop_front();
                    check_field("status", want.status, result_data.status);
                    check_field("channels", want.channels, result_data.channels);
                    check_field("bits_per_sample", want.bits_per_sample,
                                result_data.bits_per_sample);
                    check_field("bits_supported", want.bits_supported,
                                result_data.bits_supported);
                    check_field("sample_rate", want.sample_rate, result_data.sample_rate);
                    check_field("payload_size", want.payload_size, result_data.payload_size);
                    check_field("payload_offset", want.payload_offset,
                                result_data.payload_offset);
                    check_field("duration_ms", want.duration_ms, result_data.duration_ms);
                end
            end
            if (byte_valid && byte_ready)
                parse_byte(byte_data.file_byte, byte_data.start_of_file);
        end
        waiting = expected_headers.size();
    end

endmodule

>>> bench/wav_header_parser_tb.sv
module wav_header_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import whp_pkg::*;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     byte_valid   = 1'b0;
    whp_in_t  byte_data    = '0;
    logic     result_ready = 1'b0;
    logic     byte_ready;
    logic     result_valid;
    whp_out_t result_data;
    int       error_count;
    int       waiting_count;

    logic [7:0] wave_bytes[$];
    int         bytes_sent = 0;
    int         files_sent = 0;
    bit         calm       = 1'b0;
    bit         quiet      = 1'b0;

    always #2 clk = ~clk;

    wav_header_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    whp_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .errors       (error_count),
        .waiting      (waiting_count)
    );

    initial
    begin
        #2ms;
        $display("wav_header_parser_tb: errors");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (quiet || calm)
                result_ready <= 1'b1;
            else if (stall > 0)
            begin
                result_ready <= 1'b0;
                stall--;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                result_ready <= 1'b0;
                stall = $urandom_range(0, 4);
            end
            else
                result_ready <= 1'b1;
        end
    end

    task automatic put_word(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            wave_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic put_filler(input int n);
        repeat (n) wave_bytes.push_back(8'($urandom));
    endtask

    task automatic put_head(input logic [31:0] riff_len);
        put_word(TAG_RIFF, 4);
        put_word(riff_len, 4);
        put_word(TAG_WAVE, 4);
    endtask

    task automatic put_chunk(input logic [31:0] id, input int len);
        put_word(id, 4);
        put_word(32'(len), 4);
        put_filler(len);
    endtask

    task automatic put_data(input logic [31:0] len);
        put_word(TAG_DATA, 4);
        put_word(len, 4);
    endtask

    task automatic put_fmt(input logic [15:0] fmt_tag, input logic [15:0] chans,
                           input logic [31:0] rate, input logic [31:0] brate,
                           input logic [15:0] bits, input logic [31:0] len);
        put_word(TAG_FMT, 4);
        put_word(len, 4);
        put_word(fmt_tag, 2);
        put_word(chans, 2);
        put_word(rate, 4);
        put_word(brate, 4);
        put_word($urandom, 2);
        put_word(bits, 2);
        if (len > 32'd16)
            put_filler(int'(len - 32'd16));
    endtask

    // chunk ids: the data tag itself, near misses of fmt and data, and random ones
    function automatic logic [31:0] odd_tag();
        case ($urandom_range(0, 3))
            0: return TAG_DATA;
            1: return TAG_FMT ^ (32'd1 << $urandom_range(0, 31));
            2: return TAG_DATA ^ (32'd1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    task automatic put_random_fmt();
        logic [15:0] fmt_tag;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [31:0] brate;
        logic [31:0] len;
        fmt_tag = ($urandom_range(0, 15) == 0) ? 16'($urandom) : FORMAT_PCM;
        case ($urandom_range(0, 9))
            0: chans = '0;
            1: chans = 16'($urandom_range(3, 65535));
            default: chans = 16'($urandom_range(1, 2));
        endcase
        case ($urandom_range(0, 5))
            0: brate = '0;
            1: brate = $urandom_range(1, 16);
            default: brate = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0: bits = 16'($urandom);
            1: bits = 16'd8;
            default: bits = 16'd16;
        endcase
        case ($urandom_range(0, 5))
            0: len = $urandom_range(0, 15);
            1: len = $urandom_range(17, 24);
            default: len = 32'd16;
        endcase
        put_fmt(fmt_tag, chans, $urandom, brate, bits, len);
    endtask

    task automatic put_random_wave();
        put_head(($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom);
        repeat ($urandom_range(0, 2)) put_chunk(odd_tag(), $urandom_range(0, 9));
        put_random_fmt();
        if ($urandom_range(0, 7) == 0)
            put_random_fmt();
        if ($urandom_range(0, 4) == 0)
            put_chunk(odd_tag(), $urandom_range(0, 9));
        put_data($urandom);
        put_filler($urandom_range(0, 3));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic sof);
        if (!calm && !quiet && $urandom_range(0, 3) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= '{file_byte: b, start_of_file: sof};
        do
            @(posedge clk);
        while (!byte_ready);
    endtask

    task automatic send_wave(input bit sof_first);
        foreach (wave_bytes[i])
            send_byte(wave_bytes[i], sof_first && i == 0);
        bytes_sent += wave_bytes.size();
        files_sent++;
        wave_bytes.delete();
    endtask

    initial
    begin
        int kind;
        int idx;
        int keep;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first file straight after reset, no start marker
        put_head(32'd36);
        put_fmt(FORMAT_PCM, 16'd2, 32'd44100, 32'd176400, 16'd16, 32'd16);
        put_data(32'd1000);
        send_wave(1'b0);

        put_word(TAG_RIFF ^ 32'h0000_0001, 4);
        put_filler(4);
        send_wave(1'b1);

        put_word(TAG_RIFF, 4);
        put_word(32'd0, 4);
        put_word(TAG_WAVE ^ 32'h0100_0000, 4);
        put_filler(4);
        send_wave(1'b1);

        put_head($urandom);
        put_fmt(16'd3, 16'd2, 32'd48000, 32'd384000, 16'd32, 32'd16);
        put_data(32'd8);
        send_wave(1'b1);

        put_head($urandom);
        put_fmt(FORMAT_PCM, 16'd3, 32'd48000, 32'd384000, 16'd16, 32'd16);
        send_wave(1'b1);

        put_head($urandom);
        put_fmt(FORMAT_PCM, 16'hFFFF, 32'd8000, 32'd8000, 16'd8, 32'd16);
        send_wave(1'b1);

        // zero channels accepted, zero byte rate
        put_head(32'hFFFF_FFFF);
        put_fmt(FORMAT_PCM, 16'd0, 32'd8000, 32'd0, 16'd8, 32'd16);
        put_data(32'd0);
        send_wave(1'b1);

        // duration saturates
        put_head(32'hFFFF_FFFF);
        put_fmt(FORMAT_PCM, 16'd1, 32'hFFFF_FFFF, 32'd1, 16'd24, 32'd16);
        put_data(32'hFFFF_FFFF);
        send_wave(1'b1);

        // data before fmt, odd chunk, short fmt, then a longer fmt overriding it
        put_head(32'd0);
        put_chunk(TAG_DATA, 3);
        put_chunk(32'h5453_494C, 5);
        put_fmt(FORMAT_PCM, 16'd1, 32'd22050, 32'd44100, 16'd16, 32'd0);
        put_fmt(FORMAT_PCM, 16'd2, 32'd11025, 32'd44100, 16'hFFFF, 32'd19);
        put_chunk($urandom, 1);
        put_data(32'h0000_1234);
        send_wave(1'b1);

        // bytes after a result are ignored
        put_filler(6);
        send_wave(1'b0);

        // restart in the middle of a header
        put_head(32'd100);
        put_word(TAG_FMT, 4);
        put_filler(5);
        send_wave(1'b1);
        put_head(32'd100);
        put_fmt(FORMAT_PCM, 16'd1, 32'd16000, 32'd32000, 16'd16, 32'd16);
        put_data(32'd64);
        send_wave(1'b1);

        while (bytes_sent < 1400)
        begin
            quiet = (bytes_sent >= 1200);
            calm  = ($urandom_range(0, 5) == 0);
            kind  = $urandom_range(0, 99);
            if (kind < 70)
            begin
                put_random_wave();
                send_wave(1'b1);
            end
            else if (kind < 78)
            begin
                put_random_wave();
                idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(8, 11);
                wave_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
                send_wave(1'b1);
            end
            else if (kind < 86)
            begin
                put_random_wave();
                keep = $urandom_range(1, wave_bytes.size() - 1);
                while (wave_bytes.size() > keep)
                    void'(wave_bytes.pop_back());
                send_wave(1'b1);
            end
            else if (kind < 93)
            begin
                put_filler($urandom_range(1, 12));
                send_wave(1'b1);
            end
            else if (kind < 96)
            begin
                // long chunk abandoned by the next start marker
                put_head($urandom);
                put_word($urandom, 4);
                put_word($urandom | 32'h0000_0100, 4);
                put_filler($urandom_range(0, 6));
                send_wave(1'b1);
            end
            else
            begin
                put_random_wave();
                send_wave(1'b0);
            end
        end
        byte_valid <= 1'b0;

        while (waiting_count != 0)
            @(negedge clk);
        repeat (64) @(negedge clk);
        if (error_count == 0 && waiting_count == 0)
            $display("wav_header_parser_tb: clean");
        else
            $display("wav_header_parser_tb: errors");
        $finish;
    end

endmodule
